[design/vpid_pkg.sv]
// Shared widths, register indexes and handshake structs for the vector PID block.
package vpid_pkg;

  localparam int DATA_W    = 32;   // error and output fields, Q16.16
  localparam int INTEG_W   = 48;   // integral, Q32.16
  localparam int GAIN_W    = 16;   // one Q8.8 gain
  localparam int DT_W      = 16;   // elapsed time, Q0.16
  localparam int LIM_W     = 31;   // norm limit, unsigned Q15.16
  localparam int CFG_DW    = 48;
  localparam int CFG_IW    = 3;
  localparam int ACC_W     = 58;   // exact sum of the three gain terms
  localparam int MUL_W     = 33;   // shared signed multiplier operand
  localparam int PROD_W    = 2 * MUL_W;
  localparam int SUMSQ_W   = 64;
  localparam int ROOT_W    = 32;
  localparam int ITER_CW   = 5;
  localparam int AXES      = 3;

  localparam logic [CFG_IW-1:0] REG_KP  = 3'd0;
  localparam logic [CFG_IW-1:0] REG_KV  = 3'd1;
  localparam logic [CFG_IW-1:0] REG_KI  = 3'd2;
  localparam logic [CFG_IW-1:0] REG_LIM = 3'd3;

  localparam logic [LIM_W-1:0] LIM_RESET = 31'd1310720;
  localparam logic [ITER_CW-1:0] ITER_LAST = 5'd31;

  typedef struct packed {
    logic start;
    logic is_sqrt;
  } rd_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rd_stat_t;

  function automatic logic [GAIN_W-1:0] gain_of(input logic [CFG_DW-1:0] packed_g,
                                                input logic [1:0] axis);
    logic [GAIN_W-1:0] g;
    case (axis)
      2'd0:    g = packed_g[15:0];
      2'd1:    g = packed_g[31:16];
      2'd2:    g = packed_g[47:32];
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

[design/vector_pid_with_norm_clip.sv]
// Top level: three-axis PID with integral, norm test and vector clipping.
// One item at a time runs through a small sequencer around a single 33x33 signed
// multiplier (registered product) and a bit-serial root/divide unit. The first item
// after reset skips the integral update. Huge components are shifted right together
// until all lie below 2^31. A clipped item adds a square root and three divisions.
// in_ready_o is high only while the sequencer is idle; a finished result sits in
// the output register, so the next item is taken while it waits. Configuration
// writes are always ready.
module vector_pid_with_norm_clip (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [vpid_pkg::CFG_IW-1:0]         cfg_index_i,
  input  logic [vpid_pkg::CFG_DW-1:0]         cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [vpid_pkg::DATA_W-1:0]  pos_err_x_i,
  input  logic signed [vpid_pkg::DATA_W-1:0]  pos_err_y_i,
  input  logic signed [vpid_pkg::DATA_W-1:0]  pos_err_z_i,
  input  logic signed [vpid_pkg::DATA_W-1:0]  vel_err_x_i,
  input  logic signed [vpid_pkg::DATA_W-1:0]  vel_err_y_i,
  input  logic signed [vpid_pkg::DATA_W-1:0]  vel_err_z_i,
  input  logic [vpid_pkg::DT_W-1:0]           elapsed_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [vpid_pkg::DATA_W-1:0]  acc_x_o,
  output logic signed [vpid_pkg::DATA_W-1:0]  acc_y_o,
  output logic signed [vpid_pkg::DATA_W-1:0]  acc_z_o,
  output logic                                clipped_o
);

  typedef enum logic [15:0] {
    ST_IDLE    = 16'h0001,
    ST_INT_MUL = 16'h0002,
    ST_INT_ACC = 16'h0004,
    ST_TRM_MUL = 16'h0008,
    ST_TRM_ACC = 16'h0010,
    ST_ABS     = 16'h0020,
    ST_SHIFT   = 16'h0040,
    ST_SQ_MUL  = 16'h0080,
    ST_SQ_ACC  = 16'h0100,
    ST_LIM_MUL = 16'h0200,
    ST_LIM_CMP = 16'h0400,
    ST_ROOT    = 16'h0800,
    ST_SCL_MUL = 16'h1000,
    ST_SCL_GO  = 16'h2000,
    ST_DIV     = 16'h4000,
    ST_OUT     = 16'h8000
  } state_e;

  state_e state_q, state_d;
  logic [1:0] axis_q, sub_q;

  logic [vpid_pkg::CFG_DW-1:0] kp_q, kv_q, ki_q;
  logic [vpid_pkg::LIM_W-1:0]  lim_q;
  logic                        started_q;

  logic signed [vpid_pkg::DATA_W-1:0]  pos_q [vpid_pkg::AXES];
  logic signed [vpid_pkg::DATA_W-1:0]  vel_q [vpid_pkg::AXES];
  logic [vpid_pkg::DT_W-1:0]           dt_q;
  logic signed [vpid_pkg::INTEG_W-1:0] integ_q [vpid_pkg::AXES];
  logic signed [vpid_pkg::ACC_W-1:0]   acc_q [vpid_pkg::AXES];
  logic [vpid_pkg::ACC_W-1:0]          mag_q [vpid_pkg::AXES];
  logic signed [vpid_pkg::DATA_W-1:0]  res_q [vpid_pkg::AXES];
  logic signed [vpid_pkg::PROD_W-1:0]  prod_q;
  logic signed [vpid_pkg::INTEG_W-1:0] hold_q;
  logic [vpid_pkg::SUMSQ_W-1:0]        sumsq_q;
  logic [vpid_pkg::ROOT_W-1:0]         norm_q;
  logic                                shifted_q, clip_q;

  logic                                out_valid_q, clipped_q;
  logic signed [vpid_pkg::DATA_W-1:0]  out_x_q, out_y_q, out_z_q;

  logic signed [vpid_pkg::MUL_W-1:0]   mul_a, mul_b;
  logic [vpid_pkg::GAIN_W-1:0]         gain;
  logic signed [vpid_pkg::ACC_W-1:0]   term, term_i;
  logic signed [vpid_pkg::DATA_W-1:0]  inc;
  logic signed [vpid_pkg::INTEG_W:0]   isum;
  logic                                any_hi, clip_now, in_acc, out_free;

  vpid_pkg::rd_req_t                   rd_req;
  vpid_pkg::rd_stat_t                  rd_stat;
  logic [vpid_pkg::ROOT_W-1:0]         rd_result;

  function automatic logic signed [vpid_pkg::DATA_W-1:0] sat_out(
      input logic signed [vpid_pkg::ACC_W-1:0] v);
    logic signed [vpid_pkg::DATA_W-1:0] r;
    if (v[vpid_pkg::ACC_W-1:vpid_pkg::DATA_W-1] == '0 ||
        v[vpid_pkg::ACC_W-1:vpid_pkg::DATA_W-1] == '1) begin
      r = v[vpid_pkg::DATA_W-1:0];
    end else if (v[vpid_pkg::ACC_W-1]) begin
      r = {1'b1, {(vpid_pkg::DATA_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(vpid_pkg::DATA_W-1){1'b1}}};
    end
    return r;
  endfunction

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  // Shared multiplier operand select.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (sub_q)
      2'd0:    gain = vpid_pkg::gain_of(kp_q, axis_q);
      2'd1:    gain = vpid_pkg::gain_of(kv_q, axis_q);
      default: gain = vpid_pkg::gain_of(ki_q, axis_q);
    endcase
    case (state_q)
      ST_INT_MUL: begin
        mul_a = vpid_pkg::MUL_W'(pos_q[axis_q]);
        mul_b = {17'd0, dt_q};
      end
      ST_TRM_MUL: begin
        mul_a = {17'd0, gain};
        case (sub_q)
          2'd0:    mul_b = vpid_pkg::MUL_W'(pos_q[axis_q]);
          2'd1:    mul_b = vpid_pkg::MUL_W'(vel_q[axis_q]);
          2'd2:    mul_b = {integ_q[axis_q][47], integ_q[axis_q][47:16]};
          default: mul_b = {17'd0, integ_q[axis_q][15:0]};
        endcase
      end
      ST_SQ_MUL: begin
        mul_a = {2'b00, mag_q[axis_q][30:0]};
        mul_b = {2'b00, mag_q[axis_q][30:0]};
      end
      ST_LIM_MUL: begin
        mul_a = {2'b00, lim_q};
        mul_b = {2'b00, lim_q};
      end
      ST_SCL_MUL: begin
        mul_a = {2'b00, mag_q[axis_q][30:0]};
        mul_b = {2'b00, lim_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    term   = vpid_pkg::ACC_W'(prod_q >>> 8);
    term_i = vpid_pkg::ACC_W'(((vpid_pkg::PROD_W'(hold_q)) <<< 16) + prod_q >>> 8);
    inc    = prod_q[47:16];
    isum   = (vpid_pkg::INTEG_W+1)'(integ_q[axis_q]) + (vpid_pkg::INTEG_W+1)'(inc);
    any_hi = |(mag_q[0][vpid_pkg::ACC_W-1:31] | mag_q[1][vpid_pkg::ACC_W-1:31] |
               mag_q[2][vpid_pkg::ACC_W-1:31]);
    clip_now = shifted_q || (sumsq_q > prod_q[vpid_pkg::SUMSQ_W-1:0]);
  end

  assign rd_req.start   = (state_q == ST_LIM_CMP && clip_now) || (state_q == ST_SCL_GO);
  assign rd_req.is_sqrt = (state_q == ST_LIM_CMP);

  vpid_rootdiv u_rootdiv (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (rd_req),
    .operand_i (rd_req.is_sqrt ? sumsq_q : prod_q[63:0]),
    .divisor_i (norm_q),
    .stat_o    (rd_stat),
    .result_o  (rd_result)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (in_valid_i) state_d = started_q ? ST_INT_MUL : ST_TRM_MUL;
      ST_INT_MUL: state_d = ST_INT_ACC;
      ST_INT_ACC: state_d = (axis_q == 2'd2) ? ST_TRM_MUL : ST_INT_MUL;
      ST_TRM_MUL: state_d = ST_TRM_ACC;
      ST_TRM_ACC: begin
        if (sub_q == 2'd3 && axis_q == 2'd2) state_d = ST_ABS;
        else                                 state_d = ST_TRM_MUL;
      end
      ST_ABS:     state_d = ST_SHIFT;
      ST_SHIFT:   if (!any_hi) state_d = ST_SQ_MUL;
      ST_SQ_MUL:  state_d = ST_SQ_ACC;
      ST_SQ_ACC:  state_d = (axis_q == 2'd2) ? ST_LIM_MUL : ST_SQ_MUL;
      ST_LIM_MUL: state_d = ST_LIM_CMP;
      ST_LIM_CMP: state_d = clip_now ? ST_ROOT : ST_OUT;
      ST_ROOT:    if (rd_stat.done) state_d = ST_SCL_MUL;
      ST_SCL_MUL: state_d = ST_SCL_GO;
      ST_SCL_GO:  state_d = ST_DIV;
      ST_DIV:     if (rd_stat.done) state_d = (axis_q == 2'd2) ? ST_OUT : ST_SCL_MUL;
      ST_OUT:     if (out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Control, configuration and persistent state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= '0;
      sub_q       <= '0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
      kp_q        <= '0;
      kv_q        <= '0;
      ki_q        <= '0;
      lim_q       <= vpid_pkg::LIM_RESET;
      for (int a = 0; a < vpid_pkg::AXES; a++) integ_q[a] <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          vpid_pkg::REG_KP:  kp_q  <= cfg_data_i;
          vpid_pkg::REG_KV:  kv_q  <= cfg_data_i;
          vpid_pkg::REG_KI:  ki_q  <= cfg_data_i;
          vpid_pkg::REG_LIM: lim_q <= cfg_data_i[vpid_pkg::LIM_W-1:0];
          default: ;
        endcase
      end
      // Load a new result, or drop the current one once taken.
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          axis_q <= '0;
          sub_q  <= '0;
          if (in_valid_i && !started_q) begin
            started_q <= 1'b1;
            for (int a = 0; a < vpid_pkg::AXES; a++) integ_q[a] <= '0;
          end
        end
        ST_INT_ACC: begin
          // Saturate the integral to its 48-bit range.
          if (isum[vpid_pkg::INTEG_W] != isum[vpid_pkg::INTEG_W-1]) begin
            integ_q[axis_q] <= isum[vpid_pkg::INTEG_W] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
          end else begin
            integ_q[axis_q] <= isum[vpid_pkg::INTEG_W-1:0];
          end
          axis_q <= (axis_q == 2'd2) ? 2'd0 : axis_q + 1'b1;
        end
        ST_TRM_ACC: begin
          sub_q <= sub_q + 1'b1;
          if (sub_q == 2'd3) axis_q <= (axis_q == 2'd2) ? 2'd0 : axis_q + 1'b1;
        end
        ST_SQ_ACC:  axis_q <= (axis_q == 2'd2) ? 2'd0 : axis_q + 1'b1;
        ST_DIV:     if (rd_stat.done) axis_q <= (axis_q == 2'd2) ? 2'd0 : axis_q + 1'b1;
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (in_acc) begin
      pos_q[0] <= pos_err_x_i;
      pos_q[1] <= pos_err_y_i;
      pos_q[2] <= pos_err_z_i;
      vel_q[0] <= vel_err_x_i;
      vel_q[1] <= vel_err_y_i;
      vel_q[2] <= vel_err_z_i;
      dt_q     <= elapsed_i;
    end
    case (state_q)
      ST_TRM_ACC: begin
        case (sub_q)
          2'd0:    acc_q[axis_q] <= term;
          2'd1:    acc_q[axis_q] <= acc_q[axis_q] + term;
          2'd2:    hold_q <= prod_q[vpid_pkg::INTEG_W-1:0];
          default: acc_q[axis_q] <= acc_q[axis_q] + term_i;
        endcase
      end
      ST_ABS: begin
        for (int a = 0; a < vpid_pkg::AXES; a++) begin
          mag_q[a] <= acc_q[a][vpid_pkg::ACC_W-1] ? vpid_pkg::ACC_W'(-acc_q[a])
                                                  : vpid_pkg::ACC_W'(acc_q[a]);
        end
        shifted_q <= 1'b0;
        sumsq_q   <= '0;
      end
      ST_SHIFT: begin
        if (any_hi) begin
          for (int a = 0; a < vpid_pkg::AXES; a++) mag_q[a] <= mag_q[a] >> 1;
          shifted_q <= 1'b1;
        end
      end
      ST_SQ_ACC: sumsq_q <= sumsq_q + prod_q[vpid_pkg::SUMSQ_W-1:0];
      ST_LIM_CMP: begin
        clip_q <= clip_now;
        for (int a = 0; a < vpid_pkg::AXES; a++) res_q[a] <= sat_out(acc_q[a]);
      end
      ST_ROOT: if (rd_stat.done) norm_q <= rd_result;
      ST_DIV: begin
        if (rd_stat.done) begin
          if (norm_q == '0)                          res_q[axis_q] <= '0;
          else if (acc_q[axis_q][vpid_pkg::ACC_W-1]) res_q[axis_q] <= -$signed(rd_result);
          else                                       res_q[axis_q] <= $signed(rd_result);
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_x_q   <= res_q[0];
          out_y_q   <= res_q[1];
          out_z_q   <= res_q[2];
          clipped_q <= clip_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign acc_x_o     = out_x_q;
  assign acc_y_o     = out_y_q;
  assign acc_z_o     = out_z_q;
  assign clipped_o   = clipped_q;

  logic [vpid_pkg::DATA_W-1:0] abs_x;
  assign abs_x = acc_x_o[vpid_pkg::DATA_W-1] ? vpid_pkg::DATA_W'(-acc_x_o)
                                             : vpid_pkg::DATA_W'(acc_x_o);

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_stat.busy |-> !in_ready_o) else $error("item taken while root/divide busy");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o) else $error("second item taken at once");

  a_started_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q |=> started_q) else $error("started flag dropped");

  a_clip_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && clipped_o |-> abs_x <= vpid_pkg::DATA_W'(lim_q))
    else $error("clipped component exceeds limit");

endmodule

[design/vpid_rootdiv.sv]
// Bit-serial unit: floor square root of 64 bits or 64/32 division, one result bit a cycle.
module vpid_rootdiv (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  vpid_pkg::rd_req_t             req_i,
  input  logic [63:0]                   operand_i,
  input  logic [vpid_pkg::ROOT_W-1:0]   divisor_i,
  output vpid_pkg::rd_stat_t            stat_o,
  output logic [vpid_pkg::ROOT_W-1:0]   result_o
);

  logic                          busy_q, done_q, sqrt_q;
  logic [vpid_pkg::ITER_CW-1:0]  cnt_q;
  logic [63:0]                   work_q;
  logic [34:0]                   rem_q;
  logic [vpid_pkg::ROOT_W-1:0]   res_q, dvs_q;
  logic [34:0]                   rem_sh, trial, diff;
  logic                          ge;

  // One compare-subtract serves both the root digit and the quotient bit.
  always_comb begin
    if (sqrt_q) begin
      rem_sh = {rem_q[32:0], work_q[63:62]};
      trial  = {1'b0, res_q, 2'b01};
    end else begin
      rem_sh = {1'b0, rem_q[32:0], work_q[63]};
      trial  = {3'b000, dvs_q};
    end
    ge   = (rem_sh >= trial);
    diff = rem_sh - trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= vpid_pkg::ITER_LAST;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      sqrt_q <= req_i.is_sqrt;
      dvs_q  <= divisor_i;
      res_q  <= '0;
      if (req_i.is_sqrt) begin
        rem_q  <= '0;
        work_q <= operand_i;
      end else begin
        rem_q  <= {3'b000, operand_i[63:32]};
        work_q <= {operand_i[31:0], 32'd0};
      end
    end else if (busy_q) begin
      rem_q  <= ge ? diff : rem_sh;
      res_q  <= {res_q[vpid_pkg::ROOT_W-2:0], ge};
      work_q <= sqrt_q ? {work_q[61:0], 2'b00} : {work_q[62:0], 1'b0};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign result_o    = res_q;

endmodule
